// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/cvsd_pkg.sv -----
// Shared types, widths and constants of the CVSD encoder.
`default_nettype none

package cvsd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int STEP_W   = 24;
	localparam int RECON_W  = 27;
	localparam int DECAY_W  = 16;
	localparam int HIST_W   = 3;
	localparam int CNT_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int SCALE_SH = 9;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd64722;
	localparam logic [STEP_W-1:0]  INCR_RESET  = 24'd20841;
	localparam logic [HIST_W-1:0]  HIST_RESET  = 3'b101;
	localparam logic [HIST_W-1:0]  HIST_ZEROS  = 3'b000;
	localparam logic [HIST_W-1:0]  HIST_ONES   = 3'b111;
	localparam logic [STEP_W-1:0]  STEP_MAX    = 24'hFFFFFF;
	localparam logic [CNT_W-1:0]   CNT_LAST    = 3'd7;
	localparam logic signed [RECON_W:0] RECON_HI = 28'sd33554432;
	localparam logic signed [RECON_W:0] RECON_LO = -28'sd33554432;

	// Register map, by word index
	typedef enum logic [1:0] {
		REG_DECAY = 2'd0,
		REG_INCR  = 2'd1,
		REG_ORDER = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DECAY_W-1:0] decay_factor;
		logic [STEP_W-1:0]  step_increment;
		logic               msb_first;
	} cfg_t;

	typedef struct packed {
		logic              code_bit;
		logic              byte_valid;
		logic [BYTE_W-1:0] packed_byte;
		logic [STEP_W-1:0] step_now;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cvsd_ifs.sv -----
// Valid/ready channel interfaces for samples in and codes out.
`default_nettype none

interface cvsd_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [cvsd_pkg::SAMPLE_W-1:0]  sample;
	logic                                  flush;

	modport source (output valid, output sample, output flush, input ready);
	modport sink   (input valid, input sample, input flush, output ready);
endinterface

interface cvsd_out_if;
	logic                              valid;
	logic                              ready;
	logic                              code_bit;
	logic                              byte_valid;
	logic [cvsd_pkg::BYTE_W-1:0]       packed_byte;
	logic [cvsd_pkg::STEP_W-1:0]       step_now;

	modport source (output valid, output code_bit, output byte_valid,
		output packed_byte, output step_now, input ready);
	modport sink   (input valid, input code_bit, input byte_valid,
		input packed_byte, input step_now, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cvsd_encoder_core.sv -----
// Top level of the CVSD encoder: channels, APB registers, input and result stages.
//
//   channel   dir  handshake        payload
//   samples   in   valid / ready    sample[15:0] signed, flush
//   codes     out  valid / ready    code_bit, byte_valid, packed_byte[7:0], step_now[23:0]
//   apb       in   psel / penable   paddr[3:0], pwdata[31:0], prdata[31:0], pready = 1
//
// One word per cycle while codes.ready holds; words pass stage 1, then the result stage.
// The whole encoder update (24x16 step multiply, increment, integrate, pack) runs
// combinationally between the stage 1 register and the result register.
// Reset sets the encoder state and the APB registers to their defaults and clears the valid bits.
// A stalled result holds in its register; stage 1 still takes one more word meanwhile.
`default_nettype none

module cvsd_encoder_core (
	input  wire                                     clk,
	input  wire                                     arst_n,
	cvsd_in_if.sink                                 samples,
	cvsd_out_if.source                              codes,
	input  wire                                     psel,
	input  wire                                     penable,
	input  wire                                     pwrite,
	input  wire  [cvsd_pkg::APB_ADDR_W-1:0]         paddr,
	input  wire  [cvsd_pkg::APB_DATA_W-1:0]         pwdata,
	output logic [cvsd_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                    pready
);

	cvsd_pkg::cfg_t     cfg_q;
	cvsd_pkg::reg_idx_t reg_idx;
	logic               wr_en;

	logic                                  valid_s1;
	logic signed [cvsd_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                                  flush_s1;
	logic                                  valid_s2;
	cvsd_pkg::res_t                        res_s2;
	cvsd_pkg::res_t                        res_c;
	logic                                  adv;
	logic                                  accept;

	// APB register file
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = cvsd_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay_factor   <= cvsd_pkg::DECAY_RESET;
			cfg_q.step_increment <= cvsd_pkg::INCR_RESET;
			cfg_q.msb_first      <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				cvsd_pkg::REG_DECAY: cfg_q.decay_factor   <= pwdata[cvsd_pkg::DECAY_W-1:0];
				cvsd_pkg::REG_INCR:  cfg_q.step_increment <= pwdata[cvsd_pkg::STEP_W-1:0];
				cvsd_pkg::REG_ORDER: cfg_q.msb_first      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cvsd_pkg::REG_DECAY: prdata = {{(cvsd_pkg::APB_DATA_W - cvsd_pkg::DECAY_W){1'b0}},
				cfg_q.decay_factor};
			cvsd_pkg::REG_INCR:  prdata = {{(cvsd_pkg::APB_DATA_W - cvsd_pkg::STEP_W){1'b0}},
				cfg_q.step_increment};
			cvsd_pkg::REG_ORDER: prdata = {{(cvsd_pkg::APB_DATA_W - 1){1'b0}}, cfg_q.msb_first};
			default:             prdata = '0;
		endcase
	end

	// Handshake: stage 1 moves on when the result register is free or being drained
	assign adv           = valid_s1 && (!valid_s2 || codes.ready);
	assign samples.ready = !valid_s1 || adv;
	assign accept        = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (codes.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Stage 1 input word
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= samples.sample;
			flush_s1  <= samples.flush;
		end
	end

	// Encoder update
	cvsd_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.adv    (adv),
		.sample (sample_s1),
		.flush  (flush_s1),
		.res    (res_c)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign codes.valid       = valid_s2;
	assign codes.code_bit    = res_s2.code_bit;
	assign codes.byte_valid  = res_s2.byte_valid;
	assign codes.packed_byte = res_s2.packed_byte;
	assign codes.step_now    = res_s2.step_now;

endmodule

`default_nettype wire

// ----- hw/rtl/cvsd_datapath.sv -----
// Encoder state and the single-pass update: compare, step adapt, integrate, pack, or flush a partial byte.
`default_nettype none

module cvsd_datapath (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire cvsd_pkg::cfg_t                   cfg,
	input  wire                                   adv,
	input  wire logic signed [cvsd_pkg::SAMPLE_W-1:0] sample,
	input  wire                                   flush,
	output cvsd_pkg::res_t                        res
);

	localparam int RW = cvsd_pkg::RECON_W;
	localparam int SW = cvsd_pkg::STEP_W;
	localparam int DW = cvsd_pkg::DECAY_W;
	localparam int PW = SW + DW;

	// State
	logic [cvsd_pkg::HIST_W-1:0]  hist_q;
	logic [SW-1:0]                step_q;
	logic signed [RW-1:0]         recon_q;
	logic [cvsd_pkg::BYTE_W-1:0]  pack_q;
	logic [cvsd_pkg::CNT_W-1:0]   cnt_q;

	logic [cvsd_pkg::HIST_W-1:0]  hist_n;
	logic [SW-1:0]                step_n;
	logic signed [RW-1:0]         recon_n;
	logic [cvsd_pkg::BYTE_W-1:0]  pack_n;
	logic [cvsd_pkg::CNT_W-1:0]   cnt_n;

	logic signed [RW-1:0]         smp_ext;
	logic                         bit_c;
	logic [cvsd_pkg::HIST_W-1:0]  hist_c;
	logic [PW-1:0]                prod;
	logic [SW-1:0]                decayed;
	logic [SW:0]                  grown;
	logic [SW-1:0]                step_c;
	logic signed [RW:0]           recon_ext;
	logic signed [RW:0]           step_ext;
	logic signed [RW:0]           recon_sum;
	logic signed [RW-1:0]         recon_c;
	logic [cvsd_pkg::CNT_W-1:0]   pos;
	logic [cvsd_pkg::BYTE_W-1:0]  pack_or;

	// Compare sample (scaled to Q2.24) with the reconstruction
	assign smp_ext = {
		{(RW - cvsd_pkg::SAMPLE_W - cvsd_pkg::SCALE_SH){sample[cvsd_pkg::SAMPLE_W-1]}},
		sample, {cvsd_pkg::SCALE_SH{1'b0}}};
	assign bit_c  = (smp_ext > recon_q);
	assign hist_c = {hist_q[cvsd_pkg::HIST_W-2:0], bit_c};

	// Step decay, then growth on a run of three equal bits
	assign prod    = {{DW{1'b0}}, step_q} * {{SW{1'b0}}, cfg.decay_factor};
	assign decayed = prod[PW-1:DW];
	assign grown   = {1'b0, decayed} + {1'b0, cfg.step_increment};

	always_comb begin
		if (hist_c == cvsd_pkg::HIST_ZEROS || hist_c == cvsd_pkg::HIST_ONES) begin
			step_c = grown[SW] ? cvsd_pkg::STEP_MAX : grown[SW-1:0];
		end else begin
			step_c = decayed;
		end
	end

	// Integrator with clamp to +/-2.0
	assign recon_ext = {recon_q[RW-1], recon_q};
	assign step_ext  = {{(RW + 1 - SW){1'b0}}, step_c};
	assign recon_sum = bit_c ? (recon_ext + step_ext) : (recon_ext - step_ext);

	always_comb begin
		if (recon_sum > cvsd_pkg::RECON_HI) begin
			recon_c = cvsd_pkg::RECON_HI[RW-1:0];
		end else if (recon_sum < cvsd_pkg::RECON_LO) begin
			recon_c = cvsd_pkg::RECON_LO[RW-1:0];
		end else begin
			recon_c = recon_sum[RW-1:0];
		end
	end

	// Bit position in the byte under construction
	assign pos     = cfg.msb_first ? (cvsd_pkg::CNT_LAST - cnt_q) : cnt_q;
	assign pack_or = pack_q | ({{(cvsd_pkg::BYTE_W-1){1'b0}}, bit_c} << pos);

	// Next state and result word
	always_comb begin
		hist_n  = hist_q;
		step_n  = step_q;
		recon_n = recon_q;
		pack_n  = pack_q;
		cnt_n   = cnt_q;
		res     = '0;
		if (flush) begin
			res.step_now = step_q;
			if (cnt_q != '0) begin
				res.byte_valid  = 1'b1;
				res.packed_byte = pack_q;
			end
			pack_n = '0;
			cnt_n  = '0;
		end else begin
			hist_n       = hist_c;
			step_n       = step_c;
			recon_n      = recon_c;
			res.code_bit = bit_c;
			res.step_now = step_c;
			if (cnt_q == cvsd_pkg::CNT_LAST) begin
				res.byte_valid  = 1'b1;
				res.packed_byte = pack_or;
				pack_n          = '0;
				cnt_n           = '0;
			end else begin
				pack_n = pack_or;
				cnt_n  = cnt_q + 1'b1;
			end
		end
	end

	// State registers, updated when a word leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= cvsd_pkg::HIST_RESET;
			step_q  <= '0;
			recon_q <= '0;
			pack_q  <= '0;
			cnt_q   <= '0;
		end else if (adv) begin
			hist_q  <= hist_n;
			step_q  <= step_n;
			recon_q <= recon_n;
			pack_q  <= pack_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cvsd_checker.sv -----
// Port-level checks of the CVSD encoder and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"

module cvsd_checker (
	input  wire         clk,
	input  wire         arst_n,
	cvsd_in_if.sink     samples,
	cvsd_out_if.source  codes
);

	// A new result word shows after the word that made it was taken, with the stage 1 register between them
	`ASSERT_SAME(a_rise_after_accept, clk, arst_n, $rose(codes.valid), $past(samples.valid && samples.ready, 2))

	// Input back-pressure only comes from a stalled result
	`ASSERT_SAME(a_ready_low_cause, clk, arst_n, !samples.ready, codes.valid && !codes.ready)

	// A stalled result word holds
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, codes.valid && !codes.ready, codes.valid && $stable(codes.code_bit) && $stable(codes.byte_valid) && $stable(codes.packed_byte) && $stable(codes.step_now))

endmodule

bind cvsd_encoder_core cvsd_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.samples (samples),
	.codes   (codes)
);

`default_nettype wire
